// ===== rtl/tccc_pkg.sv =====
// Shared types and constants for the text console cursor controller.
// Used by tccc_decode, tccc_issue and text_console_cursor_controller_top.
`timescale 1ns / 1ps

package tccc_pkg;

    typedef enum logic [1:0] {
        ACT_GLYPH  = 2'd0,
        ACT_SCROLL = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_CURSOR = 2'd3
    } action_t;

    // Register index taken from paddr[2]
    localparam logic REG_TEXT_COLUMNS = 1'b0;
    localparam logic REG_TEXT_ROWS    = 1'b1;

    localparam logic [7:0] TEXT_COLUMNS_RESET = 8'd80;
    localparam logic [7:0] TEXT_ROWS_RESET    = 8'd60;
    localparam logic [7:0] CURSOR_ROW_RESET   = 8'd1;
    localparam logic [7:0] CURSOR_COL_RESET   = 8'd0;

    localparam logic [7:0] CHAR_PRINT_LO = 8'd32;
    localparam logic [7:0] CHAR_PRINT_HI = 8'd127;
    localparam logic [7:0] CHAR_BS       = 8'd8;
    localparam logic [7:0] CHAR_TAB      = 8'd9;
    localparam logic [7:0] CHAR_LF       = 8'd10;
    localparam logic [7:0] CHAR_FF       = 8'd12;
    localparam logic [7:0] CHAR_CR       = 8'd13;

    // Slot order of one decoded byte: glyph or clear, scroll, cursor
    localparam int SLOT_FIRST  = 0;
    localparam int SLOT_SCROLL = 1;
    localparam int SLOT_CURSOR = 2;

    typedef struct packed {
        action_t    action;
        logic [7:0] row;
        logic [7:0] col;
        logic [7:0] prev_row;
        logic [7:0] prev_col;
        logic [6:0] glyph;
    } cmd_t;

    typedef struct packed {
        logic [2:0] pend;      // commands of the current byte not yet issued
        logic       out_load;  // a command moves into the output register
    } issue_status_t;

endpackage

// ===== rtl/tccc_decode.sv =====
// Cursor state and byte decode: turns one character into up to three commands.
// Depends on tccc_pkg.
`timescale 1ns / 1ps

module tccc_decode (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    accept,
    input  logic [7:0]              char_byte,
    input  logic [7:0]              text_columns,
    input  logic [7:0]              text_rows,
    output tccc_pkg::cmd_t [2:0]    slots,
    output logic [2:0]              mask
);
    import tccc_pkg::*;

    logic [7:0] cursor_row_reg, cursor_row_next;
    logic [7:0] cursor_col_reg, cursor_col_next;

    logic       is_print, do_glyph, do_clear, do_place, do_scroll;
    logic [8:0] target_row;
    logic [7:0] target_col;
    logic [8:0] rows_eff;
    logic [7:0] final_row;
    logic [2:0] tab_dist;
    logic [8:0] col_inc, col_tab;

    assign rows_eff = (text_rows == 8'd0) ? 9'd1 : {1'b0, text_rows};
    assign is_print = (char_byte >= CHAR_PRINT_LO) && (char_byte < CHAR_PRINT_HI);
    assign tab_dist = 3'd0 - cursor_col_reg[2:0];
    assign col_inc  = {1'b0, cursor_col_reg} + 9'd1;
    assign col_tab  = {1'b0, cursor_col_reg} + {6'd0, tab_dist};

    always_comb begin
        do_glyph   = 1'b0;
        do_clear   = 1'b0;
        do_place   = 1'b0;
        target_row = {1'b0, cursor_row_reg};
        target_col = cursor_col_reg;
        if (is_print) begin
            do_glyph = 1'b1;
            do_place = 1'b1;
            if (col_inc < {1'b0, text_columns}) begin
                target_col = col_inc[7:0];
            end else begin
                target_row = {1'b0, cursor_row_reg} + 9'd1;
                target_col = 8'd0;
            end
        end else begin
            case (char_byte)
                CHAR_BS: begin
                    if (cursor_col_reg != 8'd0) begin
                        do_place   = 1'b1;
                        target_col = cursor_col_reg - 8'd1;
                    end
                end
                CHAR_TAB: begin
                    do_place = 1'b1;
                    if (col_tab >= {1'b0, text_columns}) begin
                        target_row = {1'b0, cursor_row_reg} + 9'd1;
                        target_col = 8'd0;
                    end else begin
                        target_col = col_tab[7:0];
                    end
                end
                CHAR_LF: begin
                    do_place   = 1'b1;
                    target_row = {1'b0, cursor_row_reg} + 9'd1;
                    target_col = 8'd0;
                end
                CHAR_FF: begin
                    do_clear   = 1'b1;
                    do_place   = 1'b1;
                    target_row = {1'b0, CURSOR_ROW_RESET};
                    target_col = 8'd0;
                end
                CHAR_CR: begin
                    do_place   = 1'b1;
                    target_col = 8'd0;
                end
                default: begin
                end
            endcase
        end
    end

    // Saturate on the last row and flag one scroll
    assign do_scroll = do_place && (target_row >= rows_eff);
    assign final_row = do_scroll ? 8'(rows_eff - 9'd1) : target_row[7:0];

    always_comb begin
        slots[SLOT_FIRST]           = '0;
        slots[SLOT_FIRST].action    = do_clear ? ACT_CLEAR : ACT_GLYPH;
        if (do_glyph) begin
            slots[SLOT_FIRST].row      = cursor_row_reg;
            slots[SLOT_FIRST].col      = cursor_col_reg;
            slots[SLOT_FIRST].prev_row = cursor_row_reg;
            slots[SLOT_FIRST].prev_col = cursor_col_reg;
            slots[SLOT_FIRST].glyph    = char_byte[6:0];
        end
        slots[SLOT_SCROLL]          = '0;
        slots[SLOT_SCROLL].action   = ACT_SCROLL;
        slots[SLOT_CURSOR].action   = ACT_CURSOR;
        slots[SLOT_CURSOR].row      = final_row;
        slots[SLOT_CURSOR].col      = target_col;
        slots[SLOT_CURSOR].prev_row = cursor_row_reg;
        slots[SLOT_CURSOR].prev_col = cursor_col_reg;
        slots[SLOT_CURSOR].glyph    = 7'd0;
    end

    assign mask = {do_place, do_scroll, do_glyph | do_clear};

    always_comb begin
        cursor_row_next = cursor_row_reg;
        cursor_col_next = cursor_col_reg;
        if (accept && do_place) begin
            cursor_row_next = final_row;
            cursor_col_next = target_col;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_row_reg <= CURSOR_ROW_RESET;
            cursor_col_reg <= CURSOR_COL_RESET;
        end else begin
            cursor_row_reg <= cursor_row_next;
            cursor_col_reg <= cursor_col_next;
        end
    end

endmodule

// ===== rtl/tccc_issue.sv =====
// Command buffer for one decoded byte and the result output register.
// Depends on tccc_pkg.
`timescale 1ns / 1ps

module tccc_issue (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  tccc_pkg::cmd_t [2:0]     slots,
    input  logic [2:0]               mask,
    output logic                     m_valid,
    input  logic                     m_ready,
    output tccc_pkg::cmd_t           m_cmd,
    output logic                     m_last,
    output tccc_pkg::issue_status_t  status
);
    import tccc_pkg::*;

    cmd_t [2:0] slots_reg, slots_next;
    logic [2:0] pend_reg, pend_next;
    logic       m_valid_reg, m_valid_next;
    cmd_t       m_cmd_reg, m_cmd_next;
    logic       m_last_reg, m_last_next;

    logic       out_load, accept;
    logic [2:0] pend_rest;
    cmd_t       sel_cmd;

    assign out_load  = (pend_reg != 3'd0) && (!m_valid_reg || m_ready);
    assign pend_rest = pend_reg & (pend_reg - 3'd1);
    assign s_ready   = (pend_reg == 3'd0) || (out_load && (pend_rest == 3'd0));
    assign accept    = s_valid && s_ready;

    always_comb begin
        if (pend_reg[0]) begin
            sel_cmd = slots_reg[0];
        end else if (pend_reg[1]) begin
            sel_cmd = slots_reg[1];
        end else begin
            sel_cmd = slots_reg[2];
        end
    end

    always_comb begin
        pend_next    = pend_reg;
        slots_next   = slots_reg;
        m_valid_next = m_valid_reg;
        m_cmd_next   = m_cmd_reg;
        m_last_next  = m_last_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (out_load) begin
            m_valid_next = 1'b1;
            m_cmd_next   = sel_cmd;
            m_last_next  = (pend_rest == 3'd0);
            pend_next    = pend_rest;
        end
        if (accept) begin
            pend_next  = mask;
            slots_next = slots;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg    <= 3'd0;
            m_valid_reg <= 1'b0;
        end else begin
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        slots_reg  <= slots_next;
        m_cmd_reg  <= m_cmd_next;
        m_last_reg <= m_last_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_cmd           = m_cmd_reg;
    assign m_last          = m_last_reg;
    assign status.pend     = pend_reg;
    assign status.out_load = out_load;

endmodule

// ===== rtl/text_console_cursor_controller_top.sv =====
// Top level of the text console cursor controller: APB registers, decode and issue.
// Depends on tccc_pkg, tccc_decode and tccc_issue.
`timescale 1ns / 1ps

// Text console cursor controller. Each character byte accepted on the s_ channel
// is turned into zero to three display command transactions on the m_ channel, in
// the order glyph draw or clear screen, scroll one row, cursor placement; m_last
// marks the final command of a byte. The cursor resets to row 1, column 0.
// Rate: the result output register issues one command per cycle while m_ready
// is high; the next byte is taken in the cycle that its predecessor's last
// command enters the output register, so the command buffer never idles while
// m_ready is high. text_columns (address 0) and text_rows (address 4) are written
// through the APB port and must only change while no transaction is in flight.
module text_console_cursor_controller_top (
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // character input
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_byte,
    // display commands
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_action,
    output logic [7:0]  m_row,
    output logic [7:0]  m_col,
    output logic [7:0]  m_prev_row,
    output logic [7:0]  m_prev_col,
    output logic [6:0]  m_glyph,
    output logic        m_last
);
    import tccc_pkg::*;

    logic [7:0]    text_columns_reg, text_columns_next;
    logic [7:0]    text_rows_reg, text_rows_next;
    logic          cfg_write;
    cmd_t [2:0]    slots;
    logic [2:0]    mask;
    cmd_t          m_cmd;
    issue_status_t status;

    // Config registers: written on the access phase, no wait states
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        text_columns_next = text_columns_reg;
        text_rows_next    = text_rows_reg;
        if (cfg_write) begin
            case (paddr[2])
                REG_TEXT_COLUMNS: text_columns_next = pwdata[7:0];
                REG_TEXT_ROWS:    text_rows_next    = pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_TEXT_COLUMNS: prdata = {24'd0, text_columns_reg};
            REG_TEXT_ROWS:    prdata = {24'd0, text_rows_reg};
            default:          prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_columns_reg <= TEXT_COLUMNS_RESET;
            text_rows_reg    <= TEXT_ROWS_RESET;
        end else begin
            text_columns_reg <= text_columns_next;
            text_rows_reg    <= text_rows_next;
        end
    end

    // Decode the byte against the current cursor; advance the cursor on accept
    tccc_decode u_decode (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (s_valid && s_ready),
        .char_byte    (s_char_byte),
        .text_columns (text_columns_reg),
        .text_rows    (text_rows_reg),
        .slots        (slots),
        .mask         (mask)
    );

    // Hold the decoded commands and drain them one per cycle while m_ready is high
    tccc_issue u_issue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .slots   (slots),
        .mask    (mask),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_cmd   (m_cmd),
        .m_last  (m_last),
        .status  (status)
    );

    assign m_action   = m_cmd.action;
    assign m_row      = m_cmd.row;
    assign m_col      = m_cmd.col;
    assign m_prev_row = m_cmd.prev_row;
    assign m_prev_col = m_cmd.prev_col;
    assign m_glyph    = m_cmd.glyph;

    // No new byte while more than one command of the current byte is pending
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        ($countones(status.pend) > 1) |-> !s_ready)
        else $error("byte accepted while commands still pending");

    // A scroll or clear is always followed by a cursor placement
    a_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_action == ACT_SCROLL || m_action == ACT_CLEAR)) |-> !m_last)
        else $error("scroll or clear marked as last command");

    // A command that is not last leaves the rest of its byte pending
    a_rest_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_last) |-> (status.pend != 3'd0))
        else $error("byte lost commands after a non-last command");

    // A glyph draws where the cursor stood
    a_glyph_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_action == ACT_GLYPH) |-> (m_prev_row == m_row && m_prev_col == m_col))
        else $error("glyph position differs from previous cursor");

endmodule
